// ----- design/itp_pkg.sv -----
// Package for the trace packet decoder: packet kinds, header codes and limits.
// Used by the decoder top level; depends on nothing.
`default_nettype none

package itp_pkg;

    // Packet kinds as reported on the result channel; SYNC is internal only.
    typedef enum logic [3:0] {
        KIND_OVERFLOW = 4'd0,
        KIND_STAMP    = 4'd1,
        KIND_RESERVED = 4'd2,
        KIND_STIM     = 4'd3,
        KIND_EVENT    = 4'd4,
        KIND_EXC      = 4'd5,
        KIND_PC       = 4'd6,
        KIND_SLEEP    = 4'd7,
        KIND_TSERR    = 4'd8,
        KIND_BADHDR   = 4'd9,
        KIND_SYNC     = 4'd10
    } t_kind;

    // Header byte codes.
    localparam logic [7:0] HDR_SYNC     = 8'h00;
    localparam logic [7:0] HDR_PC       = 8'h17;
    localparam logic [7:0] HDR_EXC      = 8'h0E;
    localparam logic [7:0] HDR_EVENT    = 8'h05;
    localparam logic [7:0] HDR_SLEEP    = 8'h15;
    localparam logic [7:0] HDR_OVERFLOW = 8'h70;
    localparam logic [7:0] SYNC_END     = 8'h80;

    // Timestamp kinds.
    localparam logic [2:0] TS_KIND_SYNC     = 3'd0;
    localparam logic [2:0] TS_KIND_OVERFLOW = 3'd4;
    localparam logic [2:0] TS_KIND_RSVD     = 3'd5;

    // Timestamp length limit: reset value and clamp.
    localparam logic [3:0] MAX_TS_RESET = 4'd4;
    localparam logic [3:0] MAX_TS_CLAMP = 4'd14;

endpackage

`default_nettype wire

// ----- design/itp_byte_if.sv -----
// Input channel of the trace packet decoder: one raw trace byte per item.
// Plain valid/ready interface; no dependencies.
`default_nettype none

interface itp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] trace_byte;

    modport source (output valid, output trace_byte, input ready);
    modport sink   (input valid, input trace_byte, output ready);
endinterface

`default_nettype wire

// ----- design/itp_pkt_if.sv -----
// Result channel of the trace packet decoder: one decoded packet per item.
// Plain valid/ready interface; no dependencies.
`default_nettype none

interface itp_pkt_if;
    logic        valid;
    logic        ready;
    logic [3:0]  packet_kind;
    logic [31:0] payload;
    logic [4:0]  port;
    logic [2:0]  payload_bytes;
    logic [2:0]  timestamp_kind;
    logic [8:0]  exception_number;
    logic [1:0]  exception_function;

    modport source (
        output valid, output packet_kind, output payload, output port,
        output payload_bytes, output timestamp_kind, output exception_number,
        output exception_function, input ready
    );
    modport sink (
        input valid, input packet_kind, input payload, input port,
        input payload_bytes, input timestamp_kind, input exception_number,
        input exception_function, output ready
    );
endinterface

`default_nettype wire

// ----- design/itm_trace_packet_decoder.sv -----
// Instrumentation and watchpoint trace packet decoder, one byte per item.
// Depends on itp_pkg, itp_byte_if and itp_pkt_if.
//
// Usage: trace bytes arrive on i_byte (valid/ready). Each byte is either a
// packet header or a payload byte of the open packet. When a byte completes
// a packet, a decoded item appears on o_pkt in the cycle after that byte was
// accepted. Bytes that open a packet, sync bytes and extension continuation
// bytes produce no item.
// Throughput: one byte per cycle. The decode is a single pass of logic from
// the accepted byte and the packet state into the result register, so a new
// byte is taken every cycle while the result register is empty or is being
// drained in the same cycle.
// Stall: while o_pkt holds an item that is not taken, i_byte.ready is low.
// Reset (synchronous, active low) closes any open packet, clears the halt
// flag, empties the result register and sets the timestamp length limit to 4.
// The user must write the limit through i_cfg_we/i_cfg_wdata only while the
// block is idle; the block does not enforce this. An unknown header gives a
// bad-header item and then every byte is accepted and dropped until reset.
`default_nettype none

module itm_trace_packet_decoder
    import itp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [3:0]  i_cfg_wdata,
    itp_byte_if.sink   i_byte,
    itp_pkt_if.source  o_pkt
);

    // Packet state.
    logic        r_in_packet, n_in_packet;
    t_kind       r_kind, n_kind;
    logic [2:0]  r_pos, n_pos;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_stim_size, n_stim_size;
    logic [4:0]  r_stim_port, n_stim_port;
    logic [2:0]  r_stamp_kind, n_stamp_kind;
    logic [3:0]  r_stamp_count, n_stamp_count;
    logic        r_halted, n_halted;
    logic [3:0]  r_max_ts;

    // Result register.
    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [31:0] r_out_payload;
    logic [4:0]  r_out_port;
    logic [2:0]  r_out_bytes;
    logic [2:0]  r_out_tkind;
    logic [8:0]  r_out_exnum;
    logic [1:0]  r_out_exfun;

    // Result of the current byte.
    logic        w_emit;
    t_kind       e_kind;
    logic [31:0] e_payload;
    logic [4:0]  e_port;
    logic [2:0]  e_bytes;
    logic [2:0]  e_tkind;
    logic [8:0]  e_exnum;
    logic [1:0]  e_exfun;

    logic        w_accept;
    logic [7:0]  w_v;
    logic [2:0]  w_tc;
    logic [31:0] w_ts_bits;
    logic [3:0]  w_limit;
    logic [31:0] w_acc_exc;

    assign w_v      = i_byte.trace_byte;
    assign w_tc     = w_v[6:4];
    assign w_accept = i_byte.valid && i_byte.ready;

    // A byte is taken whenever the result register is free or drains now.
    assign i_byte.ready = !r_out_valid || o_pkt.ready;

    // Timestamp bits of this byte at its position; bits past 31 are dropped.
    always_comb begin
        case (r_stamp_count)
            4'd0, 4'd1: w_ts_bits = {25'd0, w_v[6:0]};
            4'd2:       w_ts_bits = {18'd0, w_v[6:0], 7'd0};
            4'd3:       w_ts_bits = {11'd0, w_v[6:0], 14'd0};
            4'd4:       w_ts_bits = {4'd0, w_v[6:0], 21'd0};
            4'd5:       w_ts_bits = {w_v[3:0], 28'd0};
            default:    w_ts_bits = 32'd0;
        endcase
    end

    assign w_limit   = (r_max_ts > MAX_TS_CLAMP) ? MAX_TS_CLAMP : r_max_ts;
    assign w_acc_exc = r_acc | ({24'd0, w_v} << {r_pos[0], 3'b000});

    // Decode of one byte: header when no packet is open, else payload.
    always_comb begin
        n_in_packet   = r_in_packet;
        n_kind        = r_kind;
        n_pos         = r_pos;
        n_acc         = r_acc;
        n_stim_size   = r_stim_size;
        n_stim_port   = r_stim_port;
        n_stamp_kind  = r_stamp_kind;
        n_stamp_count = r_stamp_count;
        n_halted      = r_halted;
        w_emit        = 1'b0;
        e_kind        = KIND_OVERFLOW;
        e_payload     = 32'd0;
        e_port        = 5'd0;
        e_bytes       = 3'd0;
        e_tkind       = 3'd0;
        e_exnum       = 9'd0;
        e_exfun       = 2'd0;

        if (r_halted) begin
            // Stopped after a bad header: bytes are dropped.
        end else if (!r_in_packet) begin
            if (w_v == HDR_SYNC || w_v == HDR_PC || w_v == HDR_EXC ||
                w_v == HDR_EVENT || w_v == HDR_SLEEP) begin
                n_in_packet = 1'b1;
                n_pos       = 3'd0;
                n_acc       = 32'd0;
                unique case (w_v)
                    HDR_SYNC:  n_kind = KIND_SYNC;
                    HDR_PC:    n_kind = KIND_PC;
                    HDR_EXC:   n_kind = KIND_EXC;
                    HDR_EVENT: n_kind = KIND_EVENT;
                    default:   n_kind = KIND_SLEEP;
                endcase
            end else if (w_v == HDR_OVERFLOW) begin
                w_emit = 1'b1;
                e_kind = KIND_OVERFLOW;
            end else if (w_v[3:0] == 4'd0 && w_tc != 3'd0) begin
                if (w_v[7]) begin
                    // Multi-byte timestamp opens.
                    n_stamp_kind  = w_tc[2] ? {1'b0, w_tc[1:0]} : TS_KIND_RSVD;
                    n_stamp_count = 4'd1;
                    n_in_packet   = 1'b1;
                    n_kind        = KIND_STAMP;
                    n_pos         = 3'd0;
                    n_acc         = 32'd0;
                end else begin
                    // Short timestamp carries its value in the header.
                    n_stamp_kind  = (w_tc == 3'd7) ? TS_KIND_OVERFLOW : TS_KIND_SYNC;
                    n_stamp_count = 4'd0;
                    w_emit        = 1'b1;
                    e_kind        = KIND_STAMP;
                    e_payload     = {29'd0, w_tc};
                    e_tkind       = (w_tc == 3'd7) ? TS_KIND_OVERFLOW : TS_KIND_SYNC;
                end
            end else if (w_v[1:0] != 2'd0 && !w_v[2]) begin
                // Software stimulus header.
                n_stim_port = w_v[7:3];
                case (w_v[1:0])
                    2'd1:    n_stim_size = 3'd1;
                    2'd2:    n_stim_size = 3'd2;
                    default: n_stim_size = 3'd4;
                endcase
                n_in_packet = 1'b1;
                n_kind      = KIND_STIM;
                n_pos       = 3'd0;
                n_acc       = 32'd0;
            end else if (w_v[3:0] == 4'h4 || w_v[3]) begin
                // Reserved or extension header.
                if ((w_v[3:0] == 4'h4) ? w_v[7] : (w_v[7] || w_v[2])) begin
                    n_in_packet = 1'b1;
                    n_kind      = KIND_RESERVED;
                    n_pos       = 3'd0;
                    n_acc       = 32'd0;
                end else begin
                    w_emit = 1'b1;
                    e_kind = KIND_RESERVED;
                end
            end else begin
                n_halted  = 1'b1;
                w_emit    = 1'b1;
                e_kind    = KIND_BADHDR;
                e_payload = {24'd0, w_v};
            end
        end else begin
            unique case (r_kind)
                KIND_SYNC: begin
                    if (w_v == SYNC_END) begin
                        n_in_packet = 1'b0;
                    end
                end
                KIND_STIM: begin
                    n_acc = r_acc | ({24'd0, w_v} << {r_pos[1:0], 3'b000});
                    n_pos = r_pos + 3'd1;
                    if (n_pos >= r_stim_size) begin
                        n_in_packet = 1'b0;
                        w_emit      = 1'b1;
                        e_kind      = KIND_STIM;
                        e_payload   = n_acc;
                        e_port      = r_stim_port;
                        e_bytes     = r_stim_size;
                    end
                end
                KIND_STAMP: begin
                    n_acc = r_acc | w_ts_bits;
                    if (w_v[7]) begin
                        if (r_stamp_count > w_limit) begin
                            n_in_packet = 1'b0;
                            w_emit      = 1'b1;
                            e_kind      = KIND_TSERR;
                            e_payload   = n_acc;
                            e_tkind     = r_stamp_kind;
                        end else begin
                            n_stamp_count = r_stamp_count + 4'd1;
                        end
                    end else begin
                        n_in_packet = 1'b0;
                        w_emit      = 1'b1;
                        e_kind      = KIND_STAMP;
                        e_payload   = n_acc;
                        e_tkind     = r_stamp_kind;
                    end
                end
                KIND_RESERVED: begin
                    if (!w_v[7]) begin
                        n_in_packet = 1'b0;
                        w_emit      = 1'b1;
                        e_kind      = KIND_RESERVED;
                    end
                end
                KIND_EVENT: begin
                    n_in_packet = 1'b0;
                    w_emit      = 1'b1;
                    e_kind      = KIND_EVENT;
                    e_payload   = {24'd0, w_v};
                end
                KIND_EXC: begin
                    n_acc = w_acc_exc;
                    n_pos = r_pos + 3'd1;
                    if (n_pos >= 3'd2) begin
                        n_in_packet = 1'b0;
                        w_emit      = 1'b1;
                        e_kind      = KIND_EXC;
                        e_payload   = {16'd0, w_acc_exc[15:0]};
                        e_exnum     = w_acc_exc[8:0];
                        e_exfun     = w_acc_exc[13:12];
                    end
                end
                KIND_PC: begin
                    n_acc = r_acc | ({24'd0, w_v} << {r_pos[1:0], 3'b000});
                    n_pos = r_pos + 3'd1;
                    if (n_pos >= 3'd4) begin
                        n_in_packet = 1'b0;
                        w_emit      = 1'b1;
                        e_kind      = KIND_PC;
                        e_payload   = n_acc;
                    end
                end
                KIND_SLEEP: begin
                    n_in_packet = 1'b0;
                    w_emit      = 1'b1;
                    e_kind      = KIND_SLEEP;
                end
                default: begin
                    n_in_packet = 1'b0;
                end
            endcase
        end
    end

    // Packet state and configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet   <= 1'b0;
            r_kind        <= KIND_OVERFLOW;
            r_pos         <= 3'd0;
            r_acc         <= 32'd0;
            r_stim_size   <= 3'd0;
            r_stim_port   <= 5'd0;
            r_stamp_kind  <= 3'd0;
            r_stamp_count <= 4'd0;
            r_halted      <= 1'b0;
            r_max_ts      <= MAX_TS_RESET;
        end else begin
            if (i_cfg_we) begin
                r_max_ts <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_in_packet   <= n_in_packet;
                r_kind        <= n_kind;
                r_pos         <= n_pos;
                r_acc         <= n_acc;
                r_stim_size   <= n_stim_size;
                r_stim_port   <= n_stim_port;
                r_stamp_kind  <= n_stamp_kind;
                r_stamp_count <= n_stamp_count;
                r_halted      <= n_halted;
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_pkt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_out_kind    <= e_kind;
            r_out_payload <= e_payload;
            r_out_port    <= e_port;
            r_out_bytes   <= e_bytes;
            r_out_tkind   <= e_tkind;
            r_out_exnum   <= e_exnum;
            r_out_exfun   <= e_exfun;
        end
    end

    assign o_pkt.valid              = r_out_valid;
    assign o_pkt.packet_kind        = r_out_kind;
    assign o_pkt.payload            = r_out_payload;
    assign o_pkt.port               = r_out_port;
    assign o_pkt.payload_bytes      = r_out_bytes;
    assign o_pkt.timestamp_kind     = r_out_tkind;
    assign o_pkt.exception_number   = r_out_exnum;
    assign o_pkt.exception_function = r_out_exfun;

    // Once halted, no byte may produce an item.
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !w_emit)
        else $error("decoder produced an item while halted");

    // A held, untaken item must block the input side.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_pkt.ready) |-> !i_byte.ready)
        else $error("byte accepted while result register was full");

    // Stimulus items carry a legal size.
    a_stim_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_STIM) |->
        (r_out_bytes == 3'd1 || r_out_bytes == 3'd2 || r_out_bytes == 3'd4))
        else $error("stimulus item with illegal size");

    // An open packet never sits past its last payload lane.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_packet |-> (r_pos <= 3'd3))
        else $error("byte position out of range in open packet");

    // A bad header item leaves the decoder halted on the next cycle.
    a_bad_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_emit && e_kind == KIND_BADHDR) |=> r_halted)
        else $error("bad header did not halt the decoder");

endmodule

`default_nettype wire
